[rtl/stok_pkg.sv]
// Shared types, character codes and lookup functions for the source tokenizer.
package stok_pkg;

  // Default widths and queue depth handed to the top level parameters.
  localparam int LINE_BITS_DEF   = 16;
  localparam int COLUMN_BITS_DEF = 16;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed widths of the kind and character fields.
  localparam int KIND_BITS = 4;
  localparam int CHAR_BITS = 8;

  // Scanner state.
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_COMMENT,
    MODE_HALT
  } scan_mode_t;

  // Token kinds as presented on the result channel.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_END      = 4'd0,
    KIND_NEWLINE  = 4'd1,
    KIND_LBRACE   = 4'd2,
    KIND_RBRACE   = 4'd3,
    KIND_LPAREN   = 4'd4,
    KIND_RPAREN   = 4'd5,
    KIND_COMMA    = 4'd6,
    KIND_EQUALS   = 4'd7,
    KIND_PLUS     = 4'd8,
    KIND_IDENT    = 4'd9,
    KIND_SET      = 4'd10,
    KIND_CIR      = 4'd11,
    KIND_NUMBER   = 4'd12,
    KIND_BAD_CHAR = 4'd13,
    KIND_LONE_DOT = 4'd14
  } tok_kind_t;

  // Character codes the scanner reacts to.
  localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_BITS-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_BITS-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_BITS-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_BITS-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_BITS-1:0] CH_EQUALS = 8'h3D;
  localparam logic [CHAR_BITS-1:0] CH_UNDER  = 8'h5F;
  localparam logic [CHAR_BITS-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_BITS-1:0] CH_RBRACE = 8'h7D;

  // Letters of the keyword "set", by position.
  function automatic logic [CHAR_BITS-1:0] kw_set_char(input logic [1:0] idx);
    logic [CHAR_BITS-1:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h73;
      2'd1:    ch = 8'h65;
      2'd2:    ch = 8'h74;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // Letters of the keyword "cir", by position.
  function automatic logic [CHAR_BITS-1:0] kw_cir_char(input logic [1:0] idx);
    logic [CHAR_BITS-1:0] ch;
    unique case (idx)
      2'd0:    ch = 8'h63;
      2'd1:    ch = 8'h69;
      2'd2:    ch = 8'h72;
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Kind of a single-character token; anything unknown is a bad character.
  function automatic tok_kind_t punct_kind(input logic [CHAR_BITS-1:0] c);
    tok_kind_t k;
    unique case (c)
      CH_LBRACE: k = KIND_LBRACE;
      CH_RBRACE: k = KIND_RBRACE;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_COMMA:  k = KIND_COMMA;
      CH_EQUALS: k = KIND_EQUALS;
      CH_PLUS:   k = KIND_PLUS;
      CH_SEMI:   k = KIND_NEWLINE;
      default:   k = KIND_BAD_CHAR;
    endcase
    return k;
  endfunction

endpackage

[rtl/source_tokenizer.sv]
// Top level of the streaming source tokenizer: scanner, bundle queue and output stage.
//
// The tokenizer takes one source byte per cycle and returns token descriptors on the
// result channel. The scanner front end accepts a request in every cycle in which the
// bundle queue (QUEUE_DEPTH entries, default four) has room, so input rate is one byte
// per clock while the result side keeps up. Each byte yields zero, one or two tokens;
// the output stage sends one token per cycle while out_ready is high, so a byte that
// ends a pending identifier or number and also yields its own token uses the result
// channel twice. A token reaches the result port through the bundle queue and then
// the output holding register. After an unexpected character or a lone dot the block
// swallows bytes until an end request, which restarts counting at line 1, column 1
// without an end token. Line, column and length counters saturate at their maximum
// values.
module source_tokenizer
  import stok_pkg::*;
#(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CHAR_BITS-1:0]   byte_req,
  input  logic                   at_end,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_BITS-1:0]   kind,
  output logic [CHAR_BITS-1:0]   byte_res,
  output logic [LINE_BITS-1:0]   line,
  output logic [COLUMN_BITS-1:0] column,
  output logic [LENGTH_BITS-1:0] length,
  output logic                   has_dot,
  output logic                   last
);

  localparam int TOK_W    = KIND_BITS + CHAR_BITS + LINE_BITS + COLUMN_BITS +
                            LENGTH_BITS + 1;
  localparam int BUNDLE_W = 2 * TOK_W + 1;

  logic                push;
  logic [BUNDLE_W-1:0] bundle;
  logic                q_pop;
  logic [BUNDLE_W-1:0] q_data;
  logic                q_valid;
  logic                q_full;

  assign in_ready = !q_full;

  // Scanner front end.
  stok_front #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .byte_req (byte_req),
    .at_end   (at_end),
    .push     (push),
    .bundle   (bundle)
  );

  // Bundle queue.
  stok_fifo #(
    .WIDTH (BUNDLE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (bundle),
    .pop       (q_pop),
    .rd_data   (q_data),
    .not_empty (q_valid),
    .full      (q_full)
  );

  // Output stage.
  stok_back #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .byte_res  (byte_res),
    .line      (line),
    .column    (column),
    .length    (length),
    .has_dot   (has_dot),
    .last      (last)
  );

endmodule

[rtl/stok_front.sv]
// Front end: accepts source bytes, tracks position and builds token bundles.
module stok_front
  import stok_pkg::*;
#(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int TOK_W      = KIND_BITS + CHAR_BITS + LINE_BITS + COLUMN_BITS +
                              LENGTH_BITS + 1,
  localparam int BUNDLE_W   = 2 * TOK_W + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [CHAR_BITS-1:0] byte_req,
  input  logic                 at_end,
  output logic                 push,
  output logic [BUNDLE_W-1:0]  bundle
);

  typedef struct packed {
    tok_kind_t              kind;
    logic [CHAR_BITS-1:0]   byte_val;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [LENGTH_BITS-1:0] length;
    logic                   has_dot;
  } tok_t;

  scan_mode_t             mode, mode_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [COLUMN_BITS-1:0] column_count, column_count_next;
  logic [LINE_BITS-1:0]   start_line, start_line_next;
  logic [COLUMN_BITS-1:0] start_column, start_column_next;
  logic [LENGTH_BITS-1:0] lexeme_length, lexeme_length_next;
  logic                   dot_seen, dot_seen_next;
  logic [1:0]             keyword_hits, keyword_hits_next;

  logic                   accept;
  logic                   end_item;
  logic                   ident_char;
  logic                   do_idle;
  logic                   pend_valid, idle_valid;
  tok_t                   pend_tok, idle_tok;
  tok_t                   tok0, tok1;
  logic                   two;
  logic [COLUMN_BITS-1:0] column_inc;
  logic [LINE_BITS-1:0]   line_inc;
  logic [LENGTH_BITS-1:0] length_inc;

  assign accept     = in_valid && in_ready;
  assign end_item   = at_end || (byte_req == CH_NUL);
  assign ident_char = is_alpha(byte_req) || is_digit(byte_req) || (byte_req == CH_UNDER);

  // Saturating increments of the position and length counters.
  assign column_inc = (column_count == '1) ? column_count : column_count + 1'b1;
  assign line_inc   = (line_count == '1) ? line_count : line_count + 1'b1;
  assign length_inc = (lexeme_length == '1) ? lexeme_length : lexeme_length + 1'b1;

  // Next state: pending token handling first, then the byte as seen from idle.
  always_comb begin
    mode_next          = mode;
    line_count_next    = line_count;
    column_count_next  = column_count;
    start_line_next    = start_line;
    start_column_next  = start_column;
    lexeme_length_next = lexeme_length;
    dot_seen_next      = dot_seen;
    keyword_hits_next  = keyword_hits;
    do_idle            = 1'b0;
    pend_valid         = 1'b0;
    pend_tok           = '0;
    idle_valid         = 1'b0;
    idle_tok           = '0;

    unique case (mode)
      MODE_HALT: begin
        if (end_item) begin
          mode_next          = MODE_IDLE;
          line_count_next    = LINE_BITS'(1);
          column_count_next  = COLUMN_BITS'(1);
          start_line_next    = '0;
          start_column_next  = '0;
          lexeme_length_next = '0;
          dot_seen_next      = 1'b0;
          keyword_hits_next  = 2'b11;
        end
      end
      MODE_IDENT: begin
        if (!end_item && ident_char) begin
          if (lexeme_length < LENGTH_BITS'(3)) begin
            if (byte_req != kw_set_char(lexeme_length[1:0])) keyword_hits_next[0] = 1'b0;
            if (byte_req != kw_cir_char(lexeme_length[1:0])) keyword_hits_next[1] = 1'b0;
          end else begin
            keyword_hits_next = 2'b00;
          end
          lexeme_length_next = length_inc;
          column_count_next  = column_inc;
        end else begin
          pend_valid       = 1'b1;
          pend_tok.kind    = KIND_IDENT;
          if (lexeme_length == LENGTH_BITS'(3)) begin
            if (keyword_hits[0]) pend_tok.kind = KIND_SET;
            else if (keyword_hits[1]) pend_tok.kind = KIND_CIR;
          end
          pend_tok.line   = start_line;
          pend_tok.column = start_column;
          pend_tok.length = lexeme_length;
          do_idle         = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (!end_item && (is_digit(byte_req) || (byte_req == CH_DOT && !dot_seen))) begin
          if (byte_req == CH_DOT) dot_seen_next = 1'b1;
          lexeme_length_next = length_inc;
          column_count_next  = column_inc;
        end else if (lexeme_length == LENGTH_BITS'(1) && dot_seen) begin
          // A number made of a dot alone is an error token.
          pend_valid        = 1'b1;
          pend_tok.kind     = KIND_LONE_DOT;
          pend_tok.byte_val = CH_DOT;
          pend_tok.line     = start_line;
          pend_tok.column   = start_column;
          pend_tok.length   = LENGTH_BITS'(1);
          if (end_item) begin
            mode_next          = MODE_IDLE;
            line_count_next    = LINE_BITS'(1);
            column_count_next  = COLUMN_BITS'(1);
            start_line_next    = '0;
            start_column_next  = '0;
            lexeme_length_next = '0;
            dot_seen_next      = 1'b0;
            keyword_hits_next  = 2'b11;
          end else begin
            mode_next = MODE_HALT;
          end
        end else begin
          pend_valid       = 1'b1;
          pend_tok.kind    = KIND_NUMBER;
          pend_tok.line    = start_line;
          pend_tok.column  = start_column;
          pend_tok.length  = lexeme_length;
          pend_tok.has_dot = dot_seen;
          do_idle          = 1'b1;
        end
      end
      MODE_COMMENT: begin
        if (!end_item && byte_req != CH_LF) begin
          column_count_next = column_inc;
        end else begin
          do_idle = 1'b1;
        end
      end
      MODE_IDLE: begin
        do_idle = 1'b1;
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    // The byte handled as from idle; the pending branch leaves counters untouched.
    if (do_idle) begin
      mode_next = MODE_IDLE;
      if (end_item) begin
        idle_valid         = 1'b1;
        idle_tok.kind      = KIND_END;
        idle_tok.line      = line_count;
        idle_tok.column    = column_count;
        line_count_next    = LINE_BITS'(1);
        column_count_next  = COLUMN_BITS'(1);
        start_line_next    = '0;
        start_column_next  = '0;
        lexeme_length_next = '0;
        dot_seen_next      = 1'b0;
        keyword_hits_next  = 2'b11;
      end else if (byte_req == CH_SPACE || byte_req == CH_TAB || byte_req == CH_CR) begin
        column_count_next = column_inc;
      end else if (byte_req == CH_LF) begin
        idle_valid        = 1'b1;
        idle_tok.kind     = KIND_NEWLINE;
        idle_tok.byte_val = byte_req;
        idle_tok.line     = line_count;
        idle_tok.column   = column_count;
        idle_tok.length   = LENGTH_BITS'(1);
        line_count_next   = line_inc;
        column_count_next = COLUMN_BITS'(1);
      end else if (byte_req == CH_HASH) begin
        mode_next         = MODE_COMMENT;
        column_count_next = column_inc;
      end else if (is_alpha(byte_req) || byte_req == CH_UNDER) begin
        start_line_next    = line_count;
        start_column_next  = column_count;
        lexeme_length_next = LENGTH_BITS'(1);
        keyword_hits_next  = {byte_req == kw_cir_char(2'd0), byte_req == kw_set_char(2'd0)};
        dot_seen_next      = 1'b0;
        mode_next          = MODE_IDENT;
        column_count_next  = column_inc;
      end else if (is_digit(byte_req) || byte_req == CH_DOT) begin
        start_line_next    = line_count;
        start_column_next  = column_count;
        lexeme_length_next = LENGTH_BITS'(1);
        dot_seen_next      = (byte_req == CH_DOT);
        mode_next          = MODE_NUMBER;
        column_count_next  = column_inc;
      end else begin
        idle_valid        = 1'b1;
        idle_tok.kind     = punct_kind(byte_req);
        idle_tok.byte_val = byte_req;
        idle_tok.line     = line_count;
        idle_tok.column   = column_count;
        idle_tok.length   = LENGTH_BITS'(1);
        column_count_next = column_inc;
        if (idle_tok.kind == KIND_BAD_CHAR) mode_next = MODE_HALT;
      end
    end
  end

  // Bundle assembly: a pending token always goes out ahead of the byte's own token.
  always_comb begin
    tok0 = pend_valid ? pend_tok : idle_tok;
    tok1 = idle_tok;
    two  = pend_valid && idle_valid;
  end

  assign push   = accept && (pend_valid || idle_valid);
  assign bundle = {two, tok1, tok0};

  // Scanner registers advance on every accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      line_count    <= LINE_BITS'(1);
      column_count  <= COLUMN_BITS'(1);
      start_line    <= '0;
      start_column  <= '0;
      lexeme_length <= '0;
      dot_seen      <= 1'b0;
      keyword_hits  <= 2'b11;
    end else if (accept) begin
      mode          <= mode_next;
      line_count    <= line_count_next;
      column_count  <= column_count_next;
      start_line    <= start_line_next;
      start_column  <= start_column_next;
      lexeme_length <= lexeme_length_next;
      dot_seen      <= dot_seen_next;
      keyword_hits  <= keyword_hits_next;
    end
  end

  // Position counters start from one and never wrap to zero.
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    (line_count != '0) && (column_count != '0))
    else $error("position counter reached zero");

  // A halted scanner leaves halt only on an end request.
  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_HALT && !end_item) |=> (mode == MODE_HALT))
    else $error("scanner left halt without an end request");

  // A halted scanner produces no tokens.
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_HALT) |-> !push)
    else $error("token produced while halted");

endmodule

[rtl/stok_fifo.sv]
// Small queue of token bundles between the scanner and the output stage.
module stok_fifo
  import stok_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             not_empty,
  output logic             full
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));
  assign rd_data   = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("pop from empty queue");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

[rtl/stok_back.sv]
// Back end: unpacks token bundles and presents one token per request.
module stok_back
  import stok_pkg::*;
#(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int COLUMN_BITS = COLUMN_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int TOK_W      = KIND_BITS + CHAR_BITS + LINE_BITS + COLUMN_BITS +
                              LENGTH_BITS + 1,
  localparam int BUNDLE_W   = 2 * TOK_W + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [BUNDLE_W-1:0]    q_data,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [KIND_BITS-1:0]   kind,
  output logic [CHAR_BITS-1:0]   byte_res,
  output logic [LINE_BITS-1:0]   line,
  output logic [COLUMN_BITS-1:0] column,
  output logic [LENGTH_BITS-1:0] length,
  output logic                   has_dot,
  output logic                   last
);

  typedef struct packed {
    tok_kind_t              kind;
    logic [CHAR_BITS-1:0]   byte_val;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] column;
    logic [LENGTH_BITS-1:0] length;
    logic                   has_dot;
  } tok_t;

  logic                hold_valid;
  logic [BUNDLE_W-1:0] hold;
  logic                sel;
  logic                two;
  tok_t                tok0, tok1, cur;
  logic                out_take;
  logic                load;

  assign two  = hold[BUNDLE_W-1];
  assign tok1 = tok_t'(hold[2*TOK_W-1:TOK_W]);
  assign tok0 = tok_t'(hold[TOK_W-1:0]);
  assign cur  = sel ? tok1 : tok0;

  // Output fields come from the selected half of the held bundle.
  assign out_valid = hold_valid;
  assign kind      = cur.kind;
  assign byte_res  = cur.byte_val;
  assign line      = cur.line;
  assign column    = cur.column;
  assign length    = cur.length;
  assign has_dot   = cur.has_dot;
  assign last      = sel || !two;

  // A new bundle is taken when the holding register is empty or its last token leaves.
  assign out_take = out_valid && out_ready;
  assign load     = !hold_valid || (out_take && last);
  assign q_pop    = load && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      sel        <= 1'b0;
    end else if (out_take && !last) begin
      sel <= 1'b1;
    end else if (load) begin
      hold_valid <= q_valid;
      sel        <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) hold <= q_data;
  end

  // The second token is only ever selected in a two-token bundle.
  a_sel_two: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && sel) |-> two)
    else $error("second token selected in single-token bundle");

  // Moving to the second token happens only after the first was taken.
  a_sel_after_take: assert property (@(posedge clk) disable iff (rst)
    $rose(sel) |-> $past(out_take))
    else $error("second token selected without a completed request");

  // A waiting token keeps its fields until it is taken.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({kind, byte_res, line, column, length, has_dot, last})))
    else $error("waiting token changed before it was taken");

endmodule

[bench/source_tokenizer_tb.sv]
// Self-checking testbench for the streaming source tokenizer.
module source_tokenizer_tb;
  import stok_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1800;
  localparam int TAIL_CYCLES  = 12;
  localparam int LIMIT_CYCLES = 500_000;

  typedef logic [LINE_BITS_DEF-1:0]   line_t;
  typedef logic [COLUMN_BITS_DEF-1:0] col_t;
  typedef logic [LENGTH_BITS_DEF-1:0] len_t;

  // One source byte waiting to be sent, with its idle gap and pacing flags.
  typedef struct {
    logic [CHAR_BITS-1:0] chr;
    logic                 eos;
    int unsigned          gap;
    bit                   drain;
    bit                   calm;
  } src_req_t;

  // One token descriptor as the block should return it.
  typedef struct {
    tok_kind_t            kind;
    logic [CHAR_BITS-1:0] chr;
    line_t                row;
    col_t                 col;
    len_t                 len;
    logic                 dot;
    logic                 last;
  } token_t;

  localparam string KW_SET     = "set";
  localparam string KW_CIR     = "cir";
  localparam string PUNCT      = "{}(),=+";
  localparam string WORD_CHARS =
    "_abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
  localparam string BLANKS     = " \t\r";

  string near_kw[10] = '{"se", "sett", "ce", "cirq", "sat", "cr", "Set", "s", "c_r",
                         "setcir"};

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  logic [CHAR_BITS-1:0]   byte_req  = '0;
  logic                   at_end    = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [KIND_BITS-1:0]   kind;
  logic [CHAR_BITS-1:0]   byte_res;
  line_t                  line;
  col_t                   column;
  len_t                   length;
  logic                   has_dot;
  logic                   last;

  source_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .byte_req (byte_req),
    .at_end   (at_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind     (kind),
    .byte_res (byte_res),
    .line     (line),
    .column   (column),
    .length   (length),
    .has_dot  (has_dot),
    .last     (last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  src_req_t    src_bytes[$];
  token_t      want_tokens[$];
  src_req_t    next_req;
  token_t      got_want;
  int unsigned reqs_done   = 0;
  int unsigned tokens_seen = 0;
  int unsigned errors      = 0;
  int unsigned rx_hold     = 0;
  bit          rx_calm     = 1'b0;

  // Generator state while the request list is built.
  bit          gen_calm    = 1'b0;
  bit          gen_drain   = 1'b0;
  bit          gen_absorb  = 1'b0;
  int unsigned gen_items   = 0;
  int unsigned total_reqs  = 0;

  // Scanner state mirrored by the predictor.
  scan_mode_t  mode;
  line_t       line_cnt;
  col_t        col_cnt;
  line_t       tok_line;
  col_t        tok_col;
  len_t        tok_len;
  logic        dot_flag;
  logic [1:0]  kw_hits;

  function automatic bit is_letter(input logic [CHAR_BITS-1:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z");
  endfunction

  function automatic bit is_numeral(input logic [CHAR_BITS-1:0] ch);
    return ch >= "0" && ch <= "9";
  endfunction

  function automatic void step_col();
    col_cnt = (col_cnt == '1) ? col_cnt : col_cnt + 1'b1;
  endfunction

  function automatic void grow_lexeme();
    tok_len = (tok_len == '1) ? tok_len : tok_len + 1'b1;
  endfunction

  function automatic void restart_scan();
    mode     = MODE_IDLE;
    line_cnt = line_t'(1);
    col_cnt  = col_t'(1);
    tok_line = '0;
    tok_col  = '0;
    tok_len  = '0;
    dot_flag = 1'b0;
    kw_hits  = 2'b11;
  endfunction

  function automatic token_t make_tok(input tok_kind_t k, input logic [CHAR_BITS-1:0] ch,
                                      input line_t r, input col_t c, input len_t n,
                                      input logic d);
    token_t t;
    t.kind = k;
    t.chr  = ch;
    t.row  = r;
    t.col  = c;
    t.len  = n;
    t.dot  = d;
    t.last = 1'b0;
    return t;
  endfunction

  // Advances the mirrored scanner by one request and queues the tokens it yields.
  function automatic void scan_byte(input logic [CHAR_BITS-1:0] ch, input logic eos_in);
    logic      eos;
    logic      word_ch;
    logic      consumed;
    tok_kind_t k;
    token_t    batch[$];
    eos      = eos_in || (ch == CH_NUL);
    word_ch  = is_letter(ch) || is_numeral(ch) || ch == CH_UNDER;
    consumed = 1'b0;

    // A pending token either absorbs the byte or is closed by it.
    case (mode)
      MODE_HALT: begin
        if (eos) restart_scan();
        consumed = 1'b1;
      end
      MODE_IDENT: begin
        if (!eos && word_ch) begin
          if (tok_len < 3) begin
            if (ch != KW_SET[int'(tok_len)]) kw_hits[0] = 1'b0;
            if (ch != KW_CIR[int'(tok_len)]) kw_hits[1] = 1'b0;
          end else begin
            kw_hits = 2'b00;
          end
          grow_lexeme();
          step_col();
          consumed = 1'b1;
        end else begin
          k = KIND_IDENT;
          if (tok_len == 3) begin
            if (kw_hits[0]) k = KIND_SET;
            else if (kw_hits[1]) k = KIND_CIR;
          end
          batch.insert(batch.size(), make_tok(k, CH_NUL, tok_line, tok_col, tok_len, 1'b0));
          mode = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (!eos && (is_numeral(ch) || (ch == CH_DOT && !dot_flag))) begin
          if (ch == CH_DOT) dot_flag = 1'b1;
          grow_lexeme();
          step_col();
          consumed = 1'b1;
        end else if (tok_len == 1 && dot_flag) begin
          // A dot on its own is an error; only the end request recovers.
          batch.insert(batch.size(), make_tok(KIND_LONE_DOT, CH_DOT, tok_line, tok_col,
                                              len_t'(1), 1'b0));
          if (eos) restart_scan();
          else mode = MODE_HALT;
          consumed = 1'b1;
        end else begin
          batch.insert(batch.size(), make_tok(KIND_NUMBER, CH_NUL, tok_line, tok_col,
                                              tok_len, dot_flag));
          mode = MODE_IDLE;
        end
      end
      MODE_COMMENT: begin
        if (!eos && ch != CH_LF) begin
          step_col();
          consumed = 1'b1;
        end else begin
          mode = MODE_IDLE;
        end
      end
      default: mode = MODE_IDLE;
    endcase

    // The byte is then treated as the start of something new.
    if (!consumed) begin
      if (eos) begin
        batch.insert(batch.size(), make_tok(KIND_END, CH_NUL, line_cnt, col_cnt,
                                            len_t'(0), 1'b0));
        restart_scan();
      end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR) begin
        step_col();
      end else if (ch == CH_LF) begin
        batch.insert(batch.size(), make_tok(KIND_NEWLINE, ch, line_cnt, col_cnt,
                                            len_t'(1), 1'b0));
        line_cnt = (line_cnt == '1) ? line_cnt : line_cnt + 1'b1;
        col_cnt  = col_t'(1);
      end else if (ch == CH_HASH) begin
        mode = MODE_COMMENT;
        step_col();
      end else if (is_letter(ch) || ch == CH_UNDER) begin
        tok_line = line_cnt;
        tok_col  = col_cnt;
        tok_len  = len_t'(1);
        kw_hits  = {ch == KW_CIR[0], ch == KW_SET[0]};
        dot_flag = 1'b0;
        mode     = MODE_IDENT;
        step_col();
      end else if (is_numeral(ch) || ch == CH_DOT) begin
        tok_line = line_cnt;
        tok_col  = col_cnt;
        tok_len  = len_t'(1);
        dot_flag = (ch == CH_DOT);
        mode     = MODE_NUMBER;
        step_col();
      end else begin
        case (ch)
          CH_LBRACE: k = KIND_LBRACE;
          CH_RBRACE: k = KIND_RBRACE;
          CH_LPAREN: k = KIND_LPAREN;
          CH_RPAREN: k = KIND_RPAREN;
          CH_COMMA:  k = KIND_COMMA;
          CH_EQUALS: k = KIND_EQUALS;
          CH_PLUS:   k = KIND_PLUS;
          CH_SEMI:   k = KIND_NEWLINE;
          default:   k = KIND_BAD_CHAR;
        endcase
        batch.insert(batch.size(), make_tok(k, ch, line_cnt, col_cnt, len_t'(1), 1'b0));
        step_col();
        if (k == KIND_BAD_CHAR) mode = MODE_HALT;
      end
    end

    if (batch.size() != 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) want_tokens.insert(want_tokens.size(), batch[i]);
  endfunction

  // Appends one request to the send list.
  task automatic put_byte(input logic [CHAR_BITS-1:0] ch, input logic eos);
    src_req_t r;
    r.chr   = ch;
    r.eos   = eos;
    r.gap   = gen_calm ? 0 : $urandom_range(0, 15);
    r.drain = gen_drain;
    r.calm  = gen_calm;
    gen_drain = 1'b0;
    src_bytes.insert(src_bytes.size(), r);
    if (!gen_absorb) gen_items++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i], 1'b0);
  endtask

  // End of source, either flagged with a random byte alongside or as a zero byte.
  task automatic put_end();
    if ($urandom_range(0, 1)) put_byte(CHAR_BITS'($urandom_range(0, 255)), 1'b1);
    else put_byte(CH_NUL, 1'b0);
  endtask

  // Appends one token's worth of source text; error sequences stop the line.
  task automatic put_token(output bit broke);
    int unsigned n;
    int unsigned dot_at;
    logic [CHAR_BITS-1:0] ch;
    broke = 1'b0;
    case ($urandom_range(0, 31))
      0, 1, 2, 3: put_text($urandom_range(0, 1) ? KW_SET : KW_CIR);
      4, 5:       put_text(near_kw[$urandom_range(0, 9)]);
      6, 7, 8, 9: begin
        put_byte(WORD_CHARS[$urandom_range(0, 52)], 1'b0);
        n = $urandom_range(0, 7);
        repeat (n) put_byte(WORD_CHARS[$urandom_range(0, 62)], 1'b0);
      end
      10, 11, 12, 13: begin
        n      = $urandom_range(1, 6);
        dot_at = $urandom_range(0, 1) ? $urandom_range(0, n) : n + 1;
        for (int i = 0; i <= n; i++) begin
          if (i == dot_at) put_byte(CH_DOT, 1'b0);
          if (i < n) put_byte(CHAR_BITS'("0" + $urandom_range(0, 9)), 1'b0);
        end
      end
      14, 15, 16, 17: put_byte(PUNCT[$urandom_range(0, 6)], 1'b0);
      18:             put_byte(CH_SEMI, 1'b0);
      19, 20, 21, 22: put_byte(BLANKS[$urandom_range(0, 2)], 1'b0);
      23, 24:         put_byte(CH_LF, 1'b0);
      25, 26: begin
        // Comment with arbitrary bytes, usually closed by a newline.
        put_byte(CH_HASH, 1'b0);
        n = $urandom_range(0, 10);
        repeat (n) begin
          ch = CHAR_BITS'($urandom_range(1, 255));
          put_byte((ch == CH_LF) ? CH_SPACE : ch, 1'b0);
        end
        if ($urandom_range(0, 3) != 0) put_byte(CH_LF, 1'b0);
      end
      27: begin
        // A second dot closes the number and opens another.
        put_byte(CHAR_BITS'("0" + $urandom_range(0, 9)), 1'b0);
        put_byte(CH_DOT, 1'b0);
        put_byte(CHAR_BITS'("0" + $urandom_range(0, 9)), 1'b0);
        put_byte(CH_DOT, 1'b0);
        put_byte(CHAR_BITS'("0" + $urandom_range(0, 9)), 1'b0);
      end
      28: put_end();
      29: begin
        put_byte(CH_DOT, 1'b0);
        put_byte($urandom_range(0, 1) ? CH_DOT : WORD_CHARS[$urandom_range(0, 52)], 1'b0);
        broke = 1'b1;
      end
      default: begin
        put_byte(CHAR_BITS'($urandom_range(1, 255)), 1'b0);
        broke = 1'b1;
      end
    endcase
    // After an error a few requests are swallowed before the end request.
    if (broke) begin
      gen_absorb = 1'b1;
      n = $urandom_range(0, 3);
      repeat (n) put_byte(CHAR_BITS'($urandom_range(1, 255)), 1'b0);
      gen_absorb = 1'b0;
    end
  endtask

  // One source file: a run of tokens closed by an end request.
  task automatic put_segment();
    int unsigned n_tok;
    bit          broke;
    n_tok    = $urandom_range(3, 40);
    gen_calm = ($urandom_range(0, 3) == 0);
    broke    = 1'b0;
    if ($urandom_range(0, 7) == 0) gen_drain = 1'b1;
    for (int i = 0; i < n_tok && !broke; i++) put_token(broke);
    put_end();
  endtask

  // Sender: presents queued requests after their gaps and predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_byte(byte_req, at_end);
        reqs_done++;
      end
      if (!in_valid || in_ready) begin
        if (src_bytes.size() != 0 && src_bytes[0].gap != 0) begin
          src_bytes[0].gap = src_bytes[0].gap - 1;
          in_valid <= 1'b0;
        end else if (src_bytes.size() != 0 &&
                     !(src_bytes[0].drain && want_tokens.size() != 0)) begin
          next_req = src_bytes.pop_front();
          byte_req <= next_req.chr;
          at_end   <= next_req.eos;
          in_valid <= 1'b1;
          rx_calm  = next_req.calm;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stalls at random and checks every token against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_hold   = 0;
    end else begin
      if (out_valid && out_ready) begin
        tokens_seen++;
        if (want_tokens.size() == 0) begin
          $error("token of kind %0d at line %0d column %0d arrived with none expected",
                 kind, line, column);
          errors++;
        end else begin
          got_want = want_tokens.pop_front();
          if (kind !== got_want.kind) begin
            $error("kind: expected %0d, got %0d", got_want.kind, kind);
            errors++;
          end
          if (byte_res !== got_want.chr) begin
            $error("byte_res: expected %0d, got %0d", got_want.chr, byte_res);
            errors++;
          end
          if (line !== got_want.row) begin
            $error("line: expected %0d, got %0d", got_want.row, line);
            errors++;
          end
          if (column !== got_want.col) begin
            $error("column: expected %0d, got %0d", got_want.col, column);
            errors++;
          end
          if (length !== got_want.len) begin
            $error("length: expected %0d, got %0d", got_want.len, length);
            errors++;
          end
          if (has_dot !== got_want.dot) begin
            $error("has_dot: expected %0d, got %0d", got_want.dot, has_dot);
            errors++;
          end
          if (last !== got_want.last) begin
            $error("last: expected %0d, got %0d", got_want.last, last);
            errors++;
          end
        end
        rx_hold = rx_calm ? 0 : $urandom_range(0, 15);
      end else if (rx_hold != 0) begin
        rx_hold--;
      end
      out_ready <= (rx_hold == 0);
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("Timed out with %0d of %0d requests sent", reqs_done, total_reqs);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    restart_scan();

    // Keywords and identifiers closed by punctuation, every punctuation mark,
    // a dotted number, blanks, newline and a zero byte as end of source.
    put_text("set{cir(x_9,1.5=+)};\t\r\n");
    put_byte(CH_NUL, 1'b0);
    // Comment closed by the end flag, whose byte is ignored.
    put_text("#z");
    put_byte(8'hFF, 1'b1);
    // Lone dot closed by the end request: no end token.
    put_byte(CH_DOT, 1'b0);
    put_byte(8'h41, 1'b1);
    // Lone dot closed by a letter, then swallowed bytes until the end request.
    put_text(".xq");
    put_byte(CH_NUL, 1'b1);
    // Top-bit byte as an unexpected character.
    put_byte(8'hFF, 1'b0);
    put_byte(CH_NUL, 1'b0);

    // Random source files; the first waits for the block to drain.
    gen_items = 0;
    gen_drain = 1'b1;
    while (gen_items < RANDOM_ITEMS) put_segment();

    total_reqs = src_bytes.size();
    while (reqs_done < total_reqs) @(posedge clk);
    while (want_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d source requests and checked %0d tokens: all kinds, comments,",
             reqs_done, tokens_seen);
    $display("error recovery and end handling under random gaps and output stalls.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
